[rtl/lott_pkg.sv]
package lott_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int SYM_W   = 64;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 24;
    localparam int TIME_W  = 64;

    localparam int S_DATA_W = 192;
    localparam int M_DATA_W = 184;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic STATUS_FILL   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic [SYM_W-1:0]   sym;
        logic [PRICE_W-1:0] limit;
        logic [QTY_W-1:0]   qty;
        logic               buy;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller to datapath
    typedef struct packed {
        logic cap;          // capture the input item, restart scan pointers
        logic add_wr;       // append captured order at the tail
        logic rd_en;        // read entry at the scan pointer
        logic keep;         // entry survives: move it down, advance both pointers
        logic take_fill;    // entry fills: park it, push older parked fill
        logic push_rej;     // load reject result
        logic flush_last;   // push parked fill as the final result
        logic commit_count; // entry count takes the write pointer
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic kind;
        logic full;
        logic rd_done;
        logic hit;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

[rtl/lott_ram.sv]
module lott_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lott_dp.sv]
module lott_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lott_pkg::t_cmd                    i_cmd,
    output lott_pkg::t_status                 o_st,
    input  logic                              i_kind,
    input  logic [lott_pkg::S_DATA_W-1:0]     i_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_out_status,
    output logic                              o_out_last,
    output logic [lott_pkg::M_DATA_W-1:0]     o_out_data
);

    logic                               r_kind;
    logic [lott_pkg::SYM_W-1:0]         r_sym;
    logic                               r_buy;
    logic [lott_pkg::PRICE_W-1:0]       r_price;
    logic [lott_pkg::QTY_W-1:0]         r_qty;
    logic [lott_pkg::TIME_W-1:0]        r_time;

    logic [lott_pkg::CNT_W-1:0]         r_count;
    logic [lott_pkg::CNT_W-1:0]         r_rd;
    logic [lott_pkg::CNT_W-1:0]         r_wr;

    logic                               r_pend_valid;
    logic [lott_pkg::SYM_W-1:0]         r_pend_sym;
    logic [lott_pkg::QTY_W-1:0]         r_pend_qty;

    logic                               r_out_valid;
    logic                               r_out_status;
    logic                               r_out_last;
    logic [lott_pkg::SYM_W-1:0]         r_out_sym;
    logic [lott_pkg::PRICE_W-1:0]       r_out_price;
    logic [lott_pkg::QTY_W-1:0]         r_out_qty;
    logic [lott_pkg::TIME_W-1:0]        r_out_time;

    logic                               n_out_valid;

    lott_pkg::t_entry                   rd_entry;
    lott_pkg::t_entry                   wr_entry;
    logic [lott_pkg::ENTRY_W-1:0]       rd_bits;
    logic                               ram_we;
    logic [lott_pkg::IDX_W-1:0]         ram_waddr;
    logic                               push_any;

    // append at the tail, or close up a survivor during a scan
    always_comb begin
        ram_we    = i_cmd.add_wr | i_cmd.keep;
        ram_waddr = r_wr[lott_pkg::IDX_W-1:0];
        wr_entry  = rd_entry;
        if (i_cmd.add_wr) begin
            ram_waddr      = r_count[lott_pkg::IDX_W-1:0];
            wr_entry.sym   = r_sym;
            wr_entry.limit = r_price;
            wr_entry.qty   = r_qty;
            wr_entry.buy   = r_buy;
        end
    end

    lott_ram #(
        .WIDTH (lott_pkg::ENTRY_W),
        .DEPTH (lott_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_rd[lott_pkg::IDX_W-1:0]),
        .o_rdata (rd_bits)
    );

    assign rd_entry = lott_pkg::t_entry'(rd_bits);

    // capture of the input item
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind  <= i_kind;
            r_sym   <= i_data[63:0];
            r_buy   <= i_data[64];
            r_price <= i_data[96:65];
            r_qty   <= i_data[120:97];
            r_time  <= i_data[184:121];
        end
    end

    // table pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
        end else begin
            if (i_cmd.cap) begin
                r_rd <= '0;
                r_wr <= '0;
            end else begin
                if (i_cmd.keep || i_cmd.take_fill) begin
                    r_rd <= r_rd + 1'b1;
                end
                if (i_cmd.keep) begin
                    r_wr <= r_wr + 1'b1;
                end
            end
            if (i_cmd.add_wr) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.commit_count) begin
                r_count <= r_wr;
            end
        end
    end

    // one fill is parked until the next one or the scan end tells its last flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.take_fill) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush_last) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_fill) begin
            r_pend_sym <= rd_entry.sym;
            r_pend_qty <= rd_entry.qty;
        end
    end

    assign push_any = i_cmd.push_rej | i_cmd.flush_last |
                      (i_cmd.take_fill & r_pend_valid);

    always_comb begin
        n_out_valid = r_out_valid;
        if (push_any) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_rej) begin
            r_out_status <= lott_pkg::STATUS_REJECT;
            r_out_last   <= 1'b1;
            r_out_sym    <= r_sym;
            r_out_price  <= r_price;
            r_out_qty    <= r_qty;
            r_out_time   <= '0;
        end else if (push_any) begin
            r_out_status <= lott_pkg::STATUS_FILL;
            r_out_last   <= i_cmd.flush_last;
            r_out_sym    <= r_pend_sym;
            r_out_price  <= r_price;
            r_out_qty    <= r_pend_qty;
            r_out_time   <= r_time;
        end
    end

    assign o_st.kind       = r_kind;
    assign o_st.full       = (r_count == lott_pkg::CNT_W'(lott_pkg::TABLE_DEPTH));
    assign o_st.rd_done    = (r_rd == r_count);
    assign o_st.hit        = (rd_entry.sym == r_sym) && rd_entry.buy &&
                             (r_price <= rd_entry.limit);
    assign o_st.pend_valid = r_pend_valid;
    assign o_st.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;
    assign o_out_data   = {r_out_time, r_out_qty, r_out_price, r_out_sym};

endmodule

[rtl/lott_ctrl.sv]
module lott_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lott_pkg::t_status    i_st,
    output lott_pkg::t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_ADD;
                end
            end
            S_ADD: begin
                if (i_st.kind == lott_pkg::KIND_TICK) begin
                    n_state = S_RD;
                end else if (!i_st.full) begin
                    o_cmd.add_wr = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd.push_rej = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RD: begin
                if (i_st.rd_done) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_st.hit) begin
                    o_cmd.keep = 1'b1;
                    n_state    = S_RD;
                end else if (!i_st.pend_valid || i_st.out_free) begin
                    o_cmd.take_fill = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_FLUSH: begin
                o_cmd.commit_count = 1'b1;
                if (!i_st.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd.flush_last = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/limit_order_trigger_table_unit.sv]
// add item: the order is appended at the tail, or, with the table full, a reject result
// is loaded once the output is free; tick item: one table read and one compare/move per
// stored order, and no new item is taken before the tick is done; a fill leaves when the next
// fill is found or the scan ends, which settles its last flag; the table memory has a
// single registered read port; synchronous active-low reset clears the controller,
// the order count, the scan pointers, the parked fill flag and the output valid; table
// contents are not cleared, only entries below the count are ever read
module limit_order_trigger_table_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // symbol, is_buy_limit, price, quantity, timestamp, zero pad
    input  logic [lott_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // kind
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // fill_symbol, fill_price, fill_quantity, fill_time
    output logic [lott_pkg::M_DATA_W-1:0]     m_axis_tdata,
    // status
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    lott_pkg::t_cmd    cmd;
    lott_pkg::t_status st;

    lott_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    lott_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_kind       (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_last   (m_axis_tlast),
        .o_out_data   (m_axis_tdata)
    );

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.push_rej || cmd.flush_last || (cmd.take_fill && st.pend_valid))
        |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a waiting one");

    // an entry is either kept or filled, never both; at most one of keep, fill, append, reject and flush is issued
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.keep, cmd.take_fill, cmd.add_wr, cmd.push_rej, cmd.flush_last}))
        else $error("conflicting datapath commands");

    // no append into a full table
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.add_wr |-> !st.full)
        else $error("append into a full table");

    // a table read is followed by its compare or a stall on the output
    a_read_then_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_en |=> (cmd.keep || cmd.take_fill || (st.pend_valid && !st.out_free)))
        else $error("table read without a compare");

endmodule

[bench/limit_order_trigger_table_unit_tb.sv]
module limit_order_trigger_table_unit_tb;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 2 * lott_pkg::TABLE_DEPTH + 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 100;

    typedef struct packed {
        logic                         status;
        logic [lott_pkg::SYM_W-1:0]   sym;
        logic [lott_pkg::PRICE_W-1:0] price;
        logic [lott_pkg::QTY_W-1:0]   qty;
        logic [lott_pkg::TIME_W-1:0]  stamp;
        logic                         last;
    } t_fill_report;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [lott_pkg::S_DATA_W-1:0]   s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [lott_pkg::M_DATA_W-1:0]   m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;

    // shadow order book
    lott_pkg::t_entry book [lott_pkg::TABLE_DEPTH];
    int               book_count;
    t_fill_report     fills_due [$];

    int error_count;
    int cycle_count;
    int n_adds;
    int n_ticks;
    int n_fills;
    int n_rejects;
    int n_checked;
    int burst_left;
    int nonbuy_budget;

    // sender and receiver pacing
    bit sender_steady;
    bit sink_steady;
    bit sink_on;
    int run_left;
    int stall_max;
    int hold_req;
    int hold_left;

    limit_order_trigger_table_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles, %0d fills outstanding",
                     $time, cycle_count, fills_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: own stall pattern plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (run_left == 0) begin
                sink_on  = !sink_on;
                run_left = sink_on ? $urandom_range(1, 8) : $urandom_range(1, stall_max);
            end
            run_left--;
            m_axis_tready <= sink_on;
        end
    end

    function automatic void check_field(input string name, input logic [63:0] exp,
                                        input logic [63:0] act);
        if (exp !== act) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t %s mismatch: expected %h, got %h", $time, name, exp, act);
        end
    endfunction

    task automatic check_result(input t_fill_report exp);
        n_checked++;
        check_field("status", 64'(exp.status), 64'(m_axis_tuser));
        check_field("symbol", exp.sym, m_axis_tdata[63:0]);
        check_field("price", 64'(exp.price), 64'(m_axis_tdata[95:64]));
        check_field("quantity", 64'(exp.qty), 64'(m_axis_tdata[119:96]));
        check_field("time", exp.stamp, m_axis_tdata[183:120]);
        check_field("last", 64'(exp.last), 64'(m_axis_tlast));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (fills_due.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t unexpected item: status %b data %h last %b", $time,
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                check_result(fills_due.pop_front());
            end
        end
    end

    // apply one accepted item to the shadow book and queue the results it causes
    function automatic void book_apply(input logic kind, input lott_pkg::t_entry ord,
                                       input logic [lott_pkg::TIME_W-1:0] stamp);
        t_fill_report rep;
        int           wr;
        int           first;
        if (kind == lott_pkg::KIND_ADD) begin
            n_adds++;
            if (book_count < lott_pkg::TABLE_DEPTH) begin
                book[book_count] = ord;
                book_count++;
            end else begin
                n_rejects++;
                rep.status = lott_pkg::STATUS_REJECT;
                rep.sym    = ord.sym;
                rep.price  = ord.limit;
                rep.qty    = ord.qty;
                rep.stamp  = '0;
                rep.last   = 1'b1;
                fills_due.insert(fills_due.size(), rep);
            end
        end else begin
            n_ticks++;
            wr    = 0;
            first = fills_due.size();
            for (int rd = 0; rd < book_count; rd++) begin
                if (book[rd].sym == ord.sym && book[rd].buy && ord.limit <= book[rd].limit) begin
                    rep.status = lott_pkg::STATUS_FILL;
                    rep.sym    = book[rd].sym;
                    rep.price  = ord.limit;
                    rep.qty    = book[rd].qty;
                    rep.stamp  = stamp;
                    rep.last   = 1'b0;
                    fills_due.insert(fills_due.size(), rep);
                    n_fills++;
                end else begin
                    book[wr] = book[rd];
                    wr++;
                end
            end
            book_count = wr;
            if (fills_due.size() > first) begin
                rep = fills_due.pop_back();
                rep.last = 1'b1;
                fills_due.insert(fills_due.size(), rep);
            end
        end
    endfunction

    task automatic send_item(input logic kind, input logic [lott_pkg::SYM_W-1:0] sym,
                             input logic buy, input logic [lott_pkg::PRICE_W-1:0] price,
                             input logic [lott_pkg::QTY_W-1:0] qty,
                             input logic [lott_pkg::TIME_W-1:0] stamp);
        lott_pkg::t_entry ord;
        int               gap;
        ord.sym   = sym;
        ord.buy   = buy;
        ord.limit = price;
        ord.qty   = qty;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, stamp, qty, price, buy, sym};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        book_apply(kind, ord, stamp);
        if (!sender_steady) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 12);
                gap        = $urandom_range(1, 6);
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic sender_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        sender_idle();
        while (fills_due.size() != 0) @(posedge i_clk);
    endtask

    // full book, rejects, one tick that fills every entry while the output is held off
    task automatic test_full_book();
        logic [lott_pkg::SYM_W-1:0] sym;
        sym = "PRESS";
        sender_steady = 1'b1;
        send_item(lott_pkg::KIND_TICK, {lott_pkg::SYM_W{1'b1}}, 1'b1, '0,
                  {lott_pkg::QTY_W{1'b1}}, {$urandom, $urandom});
        while (book_count < lott_pkg::TABLE_DEPTH)
            send_item(lott_pkg::KIND_ADD, sym, 1'b1, $urandom,
                      lott_pkg::QTY_W'($urandom_range(0, 24'hFFFFFF)), '0);
        send_item(lott_pkg::KIND_ADD, {lott_pkg::SYM_W{1'b1}}, 1'b0,
                  {lott_pkg::PRICE_W{1'b1}}, {lott_pkg::QTY_W{1'b1}},
                  {lott_pkg::TIME_W{1'b1}});
        send_item(lott_pkg::KIND_ADD, '0, 1'b1, '0, '0, {$urandom, $urandom});
        wait_drained();
        @(posedge i_clk);
        hold_req = HOLD_CYCLES;
        // tick price zero fills the whole book, then keep offering while output is held
        send_item(lott_pkg::KIND_TICK, sym, 1'b0, '0, '0, {$urandom, $urandom});
        for (int i = 0; i < 6; i++)
            send_item(lott_pkg::KIND_ADD, sym, 1'b1, $urandom,
                      lott_pkg::QTY_W'($urandom_range(0, 24'hFFFFFF)), '0);
        send_item(lott_pkg::KIND_TICK, "NOSUCH", 1'b1, '0, '0, {$urandom, $urandom});
        send_item(lott_pkg::KIND_TICK, sym, 1'b0, '0, '0, {$urandom, $urandom});
        wait_drained();
        sender_steady = 1'b0;
    endtask

    // field extremes, equal limit, price above limit, ignored fields, non-buy orders
    task automatic test_field_extremes();
        logic [lott_pkg::SYM_W-1:0] ones;
        logic [lott_pkg::SYM_W-1:0] aapl;
        ones = {lott_pkg::SYM_W{1'b1}};
        aapl = "AAPL";
        send_item(lott_pkg::KIND_ADD, ones, 1'b1, {lott_pkg::PRICE_W{1'b1}},
                  {lott_pkg::QTY_W{1'b1}}, {lott_pkg::TIME_W{1'b1}});
        send_item(lott_pkg::KIND_ADD, '0, 1'b1, '0, '0, '0);
        send_item(lott_pkg::KIND_ADD, ones, 1'b0, {lott_pkg::PRICE_W{1'b1}}, 24'd123,
                  {$urandom, $urandom});
        send_item(lott_pkg::KIND_ADD, aapl, 1'b1, 32'h0000_9600, 24'd100, '0);
        send_item(lott_pkg::KIND_ADD, aapl, 1'b1, 32'h0000_9580, 24'd200, '0);
        send_item(lott_pkg::KIND_ADD, aapl, 1'b1, 32'h0000_9700, 24'd300, '0);
        // equal and higher limits fill, lower one survives
        send_item(lott_pkg::KIND_TICK, aapl, 1'b1, 32'h0000_9600, {lott_pkg::QTY_W{1'b1}},
                  {$urandom, $urandom});
        send_item(lott_pkg::KIND_TICK, ones, 1'b0, {lott_pkg::PRICE_W{1'b1}}, '0,
                  {lott_pkg::TIME_W{1'b1}});
        send_item(lott_pkg::KIND_TICK, '0, 1'b0, 32'd1, '0, {$urandom, $urandom});
        send_item(lott_pkg::KIND_TICK, '0, 1'b1, '0, {lott_pkg::QTY_W{1'b1}}, '0);
        send_item(lott_pkg::KIND_TICK, aapl, 1'b0, 32'h0000_9581, '0, {$urandom, $urandom});
        send_item(lott_pkg::KIND_TICK, aapl, 1'b0, '0, '0, {$urandom, $urandom});
        // non-buy order stays put
        send_item(lott_pkg::KIND_TICK, ones, 1'b1, '0, '0, {$urandom, $urandom});
        send_item(lott_pkg::KIND_TICK, aapl, 1'b0, '0, '0, {lott_pkg::TIME_W{1'b1}});
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [lott_pkg::SYM_W-1:0] pool [4];
        logic [lott_pkg::SYM_W-1:0] sym;
        logic                       buy;
        int                         add_pct;
        int                         phase_left;
        pool[0] = "MSFT";
        pool[1] = "GOOG";
        pool[2] = {$urandom, $urandom};
        pool[3] = {$urandom, $urandom};
        phase_left = 0;
        add_pct    = 60;
        for (int i = 0; i < n_items; i++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 50);
                case ($urandom_range(0, 2))
                    0: add_pct = 45;
                    1: add_pct = 60;
                    default: add_pct = 85;
                endcase
                sender_steady = ($urandom_range(0, 3) == 0);
                sink_steady   = ($urandom_range(0, 3) == 0);
                stall_max     = $urandom_range(1, 8);
                if ($urandom_range(0, 3) == 0)
                    wait_drained();
            end
            phase_left--;
            sym = pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 99) < add_pct) begin
                // non-buy orders never leave, so only a few of them
                buy = 1'b1;
                if (nonbuy_budget > 0 && $urandom_range(0, 49) == 0) begin
                    buy = 1'b0;
                    nonbuy_budget--;
                end
                send_item(lott_pkg::KIND_ADD, sym, buy, $urandom,
                          lott_pkg::QTY_W'($urandom_range(0, 24'hFFFFFF)),
                          {$urandom, $urandom});
            end else begin
                if ($urandom_range(0, 9) == 0)
                    sym = {$urandom, $urandom};
                send_item(lott_pkg::KIND_TICK, sym, 1'($urandom_range(0, 1)), $urandom,
                          lott_pkg::QTY_W'($urandom_range(0, 24'hFFFFFF)),
                          {$urandom, $urandom});
            end
        end
        sender_steady = 1'b0;
        sink_steady   = 1'b0;
        wait_drained();
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = lott_pkg::KIND_ADD;
        m_axis_tready = 1'b0;
        book_count    = 0;
        error_count   = 0;
        cycle_count   = 0;
        n_adds        = 0;
        n_ticks       = 0;
        n_fills       = 0;
        n_rejects     = 0;
        n_checked     = 0;
        burst_left    = 0;
        nonbuy_budget = 3;
        sender_steady = 1'b0;
        sink_steady   = 1'b0;
        sink_on       = 1'b0;
        run_left      = 0;
        stall_max     = 4;
        hold_req      = 0;
        hold_left     = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_full_book();
        test_field_extremes();
        test_random_traffic(262);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("orders added %0d, ticks %0d, fills %0d, rejects %0d, results checked %0d",
                 n_adds, n_ticks, n_fills, n_rejects, n_checked);
        $display("covered full book, whole-book fill under output hold-off, bursty traffic");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", error_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/lott_pkg.sv
rtl/lott_ram.sv
rtl/lott_dp.sv
rtl/lott_ctrl.sv
rtl/limit_order_trigger_table_unit.sv
bench/limit_order_trigger_table_unit_tb.sv
